// ===== design/shpcp_pkg.sv =====
// Package for the serial hex parameter command parser.
// Holds the character codes, target codes and byte class type shared by the
// decoder, the top level and the checker. No dependencies.
package shpcp_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_TEL_ON   = 8'h54;  // 'T'
  localparam logic [7:0] CH_TEL_OFF  = 8'h74;  // 't'
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LC_A     = 8'h61;
  localparam logic [7:0] CH_LC_F     = 8'h66;
  localparam logic [7:0] CH_UC_A     = 8'h41;
  localparam logic [7:0] CH_UC_F     = 8'h46;

  // Hex letters: low nibble of 'a'/'A' is 1, so digit value = nibble + 9
  localparam logic [3:0] HEX_LETTER_ADJ = 4'd9;

  localparam int unsigned TARGET_W = 3;
  localparam int unsigned VALUE_W  = 16;

  // Target codes
  localparam logic [TARGET_W-1:0] TGT_NONE  = 3'd0;
  localparam logic [TARGET_W-1:0] TGT_GAIN  = 3'd1;
  localparam logic [TARGET_W-1:0] TGT_INTEG = 3'd2;
  localparam logic [TARGET_W-1:0] TGT_DERIV = 3'd3;
  localparam logic [TARGET_W-1:0] TGT_SETPT = 3'd4;
  localparam logic [TARGET_W-1:0] TGT_OFFS  = 3'd5;

  // Classification of one received byte
  typedef struct packed {
    logic [TARGET_W-1:0] sel;      // selection letter code, TGT_NONE if not one
    logic                is_hex;   // hex digit in either case
    logic [3:0]          hex_val;  // its value
    logic                is_term;  // ':' or newline
    logic                tel_on;
    logic                tel_off;
  } byte_class_t;

endpackage

// ===== design/shpcp_decode.sv =====
// Byte classifier for the serial hex parameter command parser.
// Pure combinational decode of one ASCII byte; uses shpcp_pkg.
module shpcp_decode (
  input  logic [7:0]                rx_byte_i,
  output shpcp_pkg::byte_class_t    class_o
);

  logic is_dec;
  logic is_lc;
  logic is_uc;

  // Digit ranges
  assign is_dec = (rx_byte_i >= shpcp_pkg::CH_ZERO) && (rx_byte_i <= shpcp_pkg::CH_NINE);
  assign is_lc  = (rx_byte_i >= shpcp_pkg::CH_LC_A) && (rx_byte_i <= shpcp_pkg::CH_LC_F);
  assign is_uc  = (rx_byte_i >= shpcp_pkg::CH_UC_A) && (rx_byte_i <= shpcp_pkg::CH_UC_F);

  always_comb begin
    class_o.is_hex  = is_dec || is_lc || is_uc;
    class_o.hex_val = is_dec ? rx_byte_i[3:0] : (rx_byte_i[3:0] + shpcp_pkg::HEX_LETTER_ADJ);
    class_o.is_term = (rx_byte_i == shpcp_pkg::CH_COLON) ||
                      (rx_byte_i == shpcp_pkg::CH_NEWLINE);
    class_o.tel_on  = (rx_byte_i == shpcp_pkg::CH_TEL_ON);
    class_o.tel_off = (rx_byte_i == shpcp_pkg::CH_TEL_OFF);

    // Selection letters, either case
    unique case (rx_byte_i)
      8'h70, 8'h50: class_o.sel = shpcp_pkg::TGT_GAIN;   // p P
      8'h69, 8'h49: class_o.sel = shpcp_pkg::TGT_INTEG;  // i I
      8'h64, 8'h44: class_o.sel = shpcp_pkg::TGT_DERIV;  // d D
      8'h73, 8'h53: class_o.sel = shpcp_pkg::TGT_SETPT;  // s S
      8'h6F, 8'h4F: class_o.sel = shpcp_pkg::TGT_OFFS;   // o O
      default:      class_o.sel = shpcp_pkg::TGT_NONE;
    endcase
  end

endmodule

// ===== design/serial_hex_parameter_command_parser.sv =====
// Top level of the serial hex parameter command parser.
// Uses shpcp_pkg and shpcp_decode.
//
// Takes one received byte per item and returns exactly one result item per
// byte, the cycle after acceptance. The byte is decoded and the parser state
// updated in the accepting cycle; the result sits in an output register. A
// new byte is accepted every cycle while the output register is empty or
// being taken, so the sustained rate is one item per clock. Results for a
// terminator that closes a number carry the selected target and value;
// update_strobe_o is high only when that target is not none.
module serial_hex_parameter_command_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         rx_byte_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               update_strobe_o,
  output logic [shpcp_pkg::TARGET_W-1:0]     update_target_o,
  output logic [shpcp_pkg::VALUE_W-1:0]      update_value_o,
  output logic                               telemetry_on_o
);

  shpcp_pkg::byte_class_t cls;

  // Parser state
  logic                            num_mode_q,  num_mode_d;
  logic [shpcp_pkg::TARGET_W-1:0]  sel_q,       sel_d;
  logic [shpcp_pkg::VALUE_W-1:0]   acc_q,       acc_d;
  logic                            tel_q,       tel_d;

  // Result register
  logic                            out_valid_q;
  logic                            strobe_q,    strobe_d;
  logic [shpcp_pkg::TARGET_W-1:0]  target_q,    target_d;
  logic [shpcp_pkg::VALUE_W-1:0]   value_q,     value_d;

  logic accept;

  shpcp_decode u_decode (
    .rx_byte_i (rx_byte_i),
    .class_o   (cls)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and result for the incoming byte; other bytes leave state alone
  always_comb begin
    num_mode_d = num_mode_q;
    sel_d      = sel_q;
    acc_d      = acc_q;
    tel_d      = tel_q;
    strobe_d   = 1'b0;
    target_d   = shpcp_pkg::TGT_NONE;
    value_d    = '0;
    if (!num_mode_q) begin
      if (cls.sel != shpcp_pkg::TGT_NONE) begin
        sel_d = cls.sel;
      end else if (cls.tel_on) begin
        tel_d = 1'b1;
      end else if (cls.tel_off) begin
        tel_d = 1'b0;
      end else if (cls.is_term) begin
        num_mode_d = 1'b1;
        acc_d      = '0;
      end
    end else begin
      if (cls.is_hex) begin
        acc_d = {acc_q[shpcp_pkg::VALUE_W-5:0], cls.hex_val};
      end else if (cls.is_term) begin
        num_mode_d = 1'b0;
        target_d   = sel_q;
        value_d    = acc_q;
        strobe_d   = (sel_q != shpcp_pkg::TGT_NONE);
        sel_d      = shpcp_pkg::TGT_NONE;
      end
    end
  end

  // Control state and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_mode_q  <= 1'b0;
      sel_q       <= shpcp_pkg::TGT_NONE;
      acc_q       <= '0;
      tel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        num_mode_q <= num_mode_d;
        sel_q      <= sel_d;
        acc_q      <= acc_d;
        tel_q      <= tel_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      strobe_q <= strobe_d;
      target_q <= target_d;
      value_q  <= value_d;
    end
  end

  // Telemetry is reported as it stands after the byte; it only changes on accept
  assign out_valid_o     = out_valid_q;
  assign update_strobe_o = strobe_q;
  assign update_target_o = target_q;
  assign update_value_o  = value_q;
  assign telemetry_on_o  = tel_q;

endmodule

// ===== design/shpcp_checker.sv =====
// Port-level checker for the serial hex parameter command parser, with its bind.
// Uses shpcp_pkg; attaches to serial_hex_parameter_command_parser.
module shpcp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               update_strobe_o,
  input logic [shpcp_pkg::TARGET_W-1:0]     update_target_o,
  input logic [shpcp_pkg::VALUE_W-1:0]      update_value_o
);

  // Strobe means exactly that a target was reported
  a_strobe_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (update_strobe_o == (update_target_o != shpcp_pkg::TGT_NONE)))
    else $error("strobe does not match reported target");

  // Reported target is a defined code
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (update_target_o <= shpcp_pkg::TGT_OFFS))
    else $error("target code out of range");

  // An empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(update_strobe_o) && $stable(update_target_o) &&
       $stable(update_value_o)))
    else $error("stalled result changed");

endmodule

bind serial_hex_parameter_command_parser shpcp_checker u_shpcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .update_strobe_o (update_strobe_o),
  .update_target_o (update_target_o),
  .update_value_o  (update_value_o)
);
